@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ sv/gshp_pkg.sv @@
// shared constants, codes and direction tables of the height predictor
`timescale 1ns / 1ps

package gshp_pkg;

	localparam int GRID_COLUMNS_DEF = 64;
	localparam int GRID_ROWS_DEF    = 64;

	localparam int HEIGHT_W = 32;
	localparam int COUNT_W  = 4;
	localparam int METH_W   = 3;
	localparam int INDEX_W  = 6;
	// sums of up to eight extrapolations of Q15.16 heights
	localparam int ACC_W    = 40;

	localparam logic FUNC_GUESS = 1'b0;
	localparam logic FUNC_STORE = 1'b1;

	localparam logic [METH_W-1:0] METH_LAST  = 3'd0;
	localparam logic [METH_W-1:0] METH_QUAD  = 3'd1;
	localparam logic [METH_W-1:0] METH_LIN   = 3'd2;
	localparam logic [METH_W-1:0] METH_PLANE = 3'd3;
	localparam logic [METH_W-1:0] METH_NEAR  = 3'd4;
	localparam logic [METH_W-1:0] METH_STORE = 3'd5;

	function automatic logic signed [1:0] dir_col(input logic [2:0] k);
		case (k)
			3'd0, 3'd1, 3'd7: dir_col = 2'sd1;
			3'd2, 3'd6:       dir_col = 2'sd0;
			default:          dir_col = -2'sd1;
		endcase
	endfunction

	function automatic logic signed [1:0] dir_row(input logic [2:0] k);
		case (k)
			3'd1, 3'd2, 3'd3: dir_row = 2'sd1;
			3'd0, 3'd4:       dir_row = 2'sd0;
			default:          dir_row = -2'sd1;
		endcase
	endfunction

	function automatic logic signed [1:0] quad_col(input logic [1:0] k);
		case (k)
			2'd0, 2'd3: quad_col = 2'sd1;
			default:    quad_col = -2'sd1;
		endcase
	endfunction

	function automatic logic signed [1:0] quad_row(input logic [1:0] k);
		case (k)
			2'd0, 2'd1: quad_row = 2'sd1;
			default:    quad_row = -2'sd1;
		endcase
	endfunction

endpackage

@@ sv/gshp_ram.sv @@
// generic single-port ram with registered read
`timescale 1ns / 1ps

module gshp_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ sv/gshp_alu.sv @@
// shared three-operand adder used by the extrapolation, divide and sign steps
`timescale 1ns / 1ps

module gshp_alu (
	input  logic signed [gshp_pkg::ACC_W-1:0] x,
	input  logic signed [gshp_pkg::ACC_W-1:0] y,
	input  logic signed [gshp_pkg::ACC_W-1:0] z,
	output logic signed [gshp_pkg::ACC_W-1:0] s
);

	assign s = x + y + z;

endmodule

@@ sv/grid_surface_height_predictor.sv @@
// top level: grid store, extrapolation sequencer, divider and nearest-cell scan
//
//  channel   signals                                            dir
//  cmd       start, busy (out), func, column_index, row_index,  in
//            measured_height
//  result    done, height_estimate, estimate_count, method_used out
//  config    initial_height_we, initial_height                  in
//
// a store is written to the ram when accepted; its result strobes in the following cycle.
// a guess keeps busy high through up to 28 neighbour reads on the single ram port,
// plus a 40-step restoring divide on the adder when an extrapolation is found.
// the nearest-cell fallback adds a ram scan of all GRID_COLUMNS*GRID_ROWS cells.
// after reset a clearing pass over all GRID_COLUMNS*GRID_ROWS cells holds busy high.
// results cannot be stalled; done is high for exactly one cycle.
`timescale 1ns / 1ps

module grid_surface_height_predictor #(
	parameter int GRID_COLUMNS = gshp_pkg::GRID_COLUMNS_DEF,
	parameter int GRID_ROWS    = gshp_pkg::GRID_ROWS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  func,
	input  logic [gshp_pkg::INDEX_W-1:0]          column_index,
	input  logic [gshp_pkg::INDEX_W-1:0]          row_index,
	input  logic signed [gshp_pkg::HEIGHT_W-1:0]  measured_height,
	output logic                                  done,
	output logic signed [gshp_pkg::HEIGHT_W-1:0]  height_estimate,
	output logic [gshp_pkg::COUNT_W-1:0]          estimate_count,
	output logic [gshp_pkg::METH_W-1:0]           method_used,
	input  logic                                  initial_height_we,
	input  logic signed [gshp_pkg::HEIGHT_W-1:0]  initial_height
);

	localparam int CELLS = GRID_COLUMNS * GRID_ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int XW    = $clog2(GRID_COLUMNS);
	localparam int YW    = $clog2(GRID_ROWS);
	localparam int XM    = (XW > gshp_pkg::INDEX_W) ? XW : gshp_pkg::INDEX_W;
	localparam int MW    = (YW > XM) ? YW : XM;
	localparam int NW    = MW + 2;
	localparam int DW    = 2 * NW;
	localparam int HW    = gshp_pkg::HEIGHT_W;
	localparam int AC    = gshp_pkg::ACC_W;
	localparam int CW    = gshp_pkg::COUNT_W;
	localparam int BW    = $clog2(AC);

	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [YW-1:0] LAST_Y    = YW'(GRID_ROWS - 1);
	localparam logic [BW-1:0] LAST_BIT  = BW'(AC - 1);
	localparam logic signed [AC-1:0] SAT_HI = {{(AC-HW+1){1'b0}}, {(HW-1){1'b1}}};
	localparam logic signed [AC-1:0] SAT_LO = {{(AC-HW+1){1'b1}}, {(HW-1){1'b0}}};

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD, S_DATA, S_Q2, S_PL2, S_TIER, S_PEND,
		S_ABS, S_DIV, S_SIGN, S_SCAN, S_DRAIN, S_NOUT
	} state_t;

	state_t state_q;

	logic [gshp_pkg::INDEX_W-1:0]  c_q, r_q;
	logic                          phase_q;
	logic [2:0]                    dir_q;
	logic [1:0]                    dist_q;
	logic signed [HW-1:0]          a_q, b_q, last_q;
	logic signed [AC-1:0]          qt_q, quad_sum_q, lin_sum_q, dq_q;
	logic [CW-1:0]                 quad_cnt_q, lin_cnt_q, div_cnt_q;
	logic [gshp_pkg::METH_W-1:0]   meth_sel_q;
	logic                          neg_q;
	logic [CW-1:0]                 rem_q;
	logic [BW-1:0]                 bit_q;
	logic                          any_valid_q;
	logic [AW-1:0]                 scan_addr_q;
	logic [XW-1:0]                 scan_x_q, x_s1;
	logic [YW-1:0]                 scan_y_q, y_s1;
	logic                          iss_s1, ok_s2;
	logic [DW-1:0]                 d2_s2, best_q;
	logic signed [HW-1:0]          h_s2, near_h_q;
	logic                          found_q, drain_q;
	logic                          done_q;
	logic signed [HW-1:0]          est_q;
	logic [CW-1:0]                 cnt_q;
	logic [gshp_pkg::METH_W-1:0]   meth_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_addr;
	logic [HW:0]          ram_wdata, ram_rdata;
	logic signed [HW-1:0] rd_h;
	logic                 rd_v;

	logic signed [AC-1:0] alu_x, alu_y, alu_z, alu_s;
	logic signed [AC-1:0] hx, ax, bx, div_src;

	logic signed [1:0] dc, dr;
	logic [NW-1:0]     dcx, drx, ofs_c, ofs_r, nc, nr;
	logic              nb_in, st_in, last_k, accept;
	logic [AW-1:0]     nb_idx, st_idx;

	logic [NW-1:0]         sdx, sdy;
	logic signed [DW-1:0]  sqx, sqy;
	logic [DW-1:0]         d2;
	logic [CW:0]           trial_in;
	logic signed [AC-1:0]  sat_v;

	gshp_ram #(.WIDTH(HW + 1), .DEPTH(CELLS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	gshp_alu u_alu (
		.x (alu_x),
		.y (alu_y),
		.z (alu_z),
		.s (alu_s)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done            = done_q;
	assign height_estimate = est_q;
	assign estimate_count  = cnt_q;
	assign method_used     = meth_q;

	assign rd_h = ram_rdata[HW-1:0];
	assign rd_v = ram_rdata[HW];
	assign hx   = {{(AC-HW){rd_h[HW-1]}}, rd_h};
	assign ax   = {{(AC-HW){a_q[HW-1]}}, a_q};
	assign bx   = {{(AC-HW){b_q[HW-1]}}, b_q};
	assign div_src = (meth_sel_q == gshp_pkg::METH_QUAD) ? quad_sum_q : lin_sum_q;

	// neighbour address: directions by distance, or the three corners of a quadrant
	always_comb begin
		if (phase_q) begin
			dc = gshp_pkg::quad_col(dir_q[1:0]);
			dr = gshp_pkg::quad_row(dir_q[1:0]);
		end else begin
			dc = gshp_pkg::dir_col(dir_q);
			dr = gshp_pkg::dir_row(dir_q);
		end
		dcx = {{(NW-2){dc[1]}}, dc};
		drx = {{(NW-2){dr[1]}}, dr};
		if (phase_q) begin
			ofs_c = (dist_q != 2'd2) ? dcx : '0;
			ofs_r = (dist_q != 2'd3) ? drx : '0;
		end else begin
			ofs_c = (dist_q[0] ? dcx : '0) + (dist_q[1] ? {dcx[NW-2:0], 1'b0} : '0);
			ofs_r = (dist_q[0] ? drx : '0) + (dist_q[1] ? {drx[NW-2:0], 1'b0} : '0);
		end
		nc = NW'(c_q) + ofs_c;
		nr = NW'(r_q) + ofs_r;
		nb_in = !nc[NW-1] && (nc < NW'(GRID_COLUMNS)) && !nr[NW-1] && (nr < NW'(GRID_ROWS));
		nb_idx = AW'(nc) * AW'(GRID_ROWS) + AW'(nr);
		st_in = (NW'(column_index) < NW'(GRID_COLUMNS)) && (NW'(row_index) < NW'(GRID_ROWS));
		st_idx = AW'(column_index) * AW'(GRID_ROWS) + AW'(row_index);
		last_k = phase_q ? (dir_q[1:0] == 2'd3) : (dir_q == 3'd7);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = {1'b1, measured_height};
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
				ram_addr  = scan_addr_q;
			end
			S_IDLE: begin
				ram_we   = accept && (func == gshp_pkg::FUNC_STORE) && st_in;
				ram_addr = st_idx;
			end
			S_SCAN:  ram_addr = scan_addr_q;
			default: ram_addr = nb_idx;
		endcase
	end

	// operand selection for the shared adder
	always_comb begin
		alu_x    = '0;
		alu_y    = '0;
		alu_z    = '0;
		trial_in = {rem_q, dq_q[AC-1]};
		case (state_q)
			S_DATA: begin
				if (phase_q) begin
					alu_x = lin_sum_q;
					alu_y = hx;
					alu_z = -ax;
				end else begin
					case (dist_q)
						2'd1: begin
							alu_y = hx <<< 1;
							alu_z = hx;
						end
						2'd2: begin
							alu_x = lin_sum_q;
							alu_y = ax <<< 1;
							alu_z = -hx;
						end
						default: begin
							alu_x = quad_sum_q;
							alu_y = qt_q;
							alu_z = hx;
						end
					endcase
				end
			end
			S_Q2: begin
				alu_x = qt_q;
				alu_y = -(bx <<< 1);
				alu_z = -bx;
			end
			S_PL2: begin
				alu_x = lin_sum_q;
				alu_y = bx;
			end
			S_ABS: begin
				alu_y = div_src[AC-1] ? ~div_src : div_src;
				alu_z = AC'(div_src[AC-1]);
			end
			S_DIV: begin
				alu_x = AC'(trial_in);
				alu_y = ~{{(AC-CW){1'b0}}, div_cnt_q};
				alu_z = AC'(1);
			end
			S_SIGN: begin
				alu_y = neg_q ? ~dq_q : dq_q;
				alu_z = AC'(neg_q);
			end
			default: begin
				alu_x = '0;
			end
		endcase
	end

	// squared distance of the scanned cell from the addressed one, and the saturated adder sum
	always_comb begin
		sdx = NW'(x_s1) - NW'(c_q);
		sdy = NW'(y_s1) - NW'(r_q);
		sqx = $signed(sdx) * $signed(sdx);
		sqy = $signed(sdy) * $signed(sdy);
		d2  = sqx + sqy;
		if (alu_s > SAT_HI) begin
			sat_v = SAT_HI;
		end else if (alu_s < SAT_LO) begin
			sat_v = SAT_LO;
		end else begin
			sat_v = alu_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			scan_addr_q <= '0;
			done_q      <= 1'b0;
			any_valid_q <= 1'b0;
			last_q      <= '0;
			iss_s1      <= 1'b0;
			ok_s2       <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (initial_height_we) begin
				last_q <= initial_height;
			end

			// scan pipeline: ram data pairs with the coordinates of stage one
			iss_s1 <= (state_q == S_SCAN);
			x_s1   <= scan_x_q;
			y_s1   <= scan_y_q;
			ok_s2  <= iss_s1 && rd_v;
			d2_s2  <= d2;
			h_s2   <= rd_h;
			if (ok_s2 && (!found_q || (d2_s2 < best_q))) begin
				found_q  <= 1'b1;
				best_q   <= d2_s2;
				near_h_q <= h_s2;
			end

			case (state_q)
				S_CLEAR: begin
					if (scan_addr_q == LAST_CELL) begin
						scan_addr_q <= '0;
						state_q     <= S_IDLE;
					end else begin
						scan_addr_q <= scan_addr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (func == gshp_pkg::FUNC_STORE) begin
							if (st_in) begin
								any_valid_q <= 1'b1;
							end
							last_q <= measured_height;
							est_q  <= '0;
							cnt_q  <= '0;
							meth_q <= gshp_pkg::METH_STORE;
							done_q <= 1'b1;
						end else begin
							c_q        <= column_index;
							r_q        <= row_index;
							phase_q    <= 1'b0;
							dir_q      <= '0;
							dist_q     <= 2'd1;
							quad_sum_q <= '0;
							lin_sum_q  <= '0;
							quad_cnt_q <= '0;
							lin_cnt_q  <= '0;
							state_q    <= S_RD;
						end
					end
				end
				S_RD: begin
					if (nb_in) begin
						state_q <= S_DATA;
					end else begin
						// a missing cell ends this direction or quadrant
						dist_q <= 2'd1;
						if (last_k) begin
							state_q <= phase_q ? S_PEND : S_TIER;
						end else begin
							dir_q   <= dir_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_DATA: begin
					if (!rd_v) begin
						dist_q <= 2'd1;
						if (last_k) begin
							state_q <= phase_q ? S_PEND : S_TIER;
						end else begin
							dir_q   <= dir_q + 1'b1;
							state_q <= S_RD;
						end
					end else begin
						case (dist_q)
							2'd1: begin
								a_q     <= rd_h;
								if (!phase_q) begin
									qt_q <= alu_s;
								end
								dist_q  <= 2'd2;
								state_q <= S_RD;
							end
							2'd2: begin
								b_q <= rd_h;
								if (phase_q) begin
									dist_q  <= 2'd3;
									state_q <= S_RD;
								end else begin
									lin_sum_q <= alu_s;
									lin_cnt_q <= lin_cnt_q + 1'b1;
									state_q   <= S_Q2;
								end
							end
							default: begin
								if (phase_q) begin
									lin_sum_q <= alu_s;
									state_q   <= S_PL2;
								end else begin
									quad_sum_q <= alu_s;
									quad_cnt_q <= quad_cnt_q + 1'b1;
									dist_q     <= 2'd1;
									if (last_k) begin
										state_q <= S_TIER;
									end else begin
										dir_q   <= dir_q + 1'b1;
										state_q <= S_RD;
									end
								end
							end
						endcase
					end
				end
				S_Q2: begin
					qt_q    <= alu_s;
					dist_q  <= 2'd3;
					state_q <= S_RD;
				end
				S_PL2: begin
					lin_sum_q <= alu_s;
					lin_cnt_q <= lin_cnt_q + 1'b1;
					dist_q    <= 2'd1;
					if (last_k) begin
						state_q <= S_PEND;
					end else begin
						dir_q   <= dir_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_TIER: begin
					if (quad_cnt_q != '0) begin
						meth_sel_q <= gshp_pkg::METH_QUAD;
						state_q    <= S_ABS;
					end else if (lin_cnt_q != '0) begin
						meth_sel_q <= gshp_pkg::METH_LIN;
						state_q    <= S_ABS;
					end else begin
						// plane tier accumulates in the linear sum, still zero here
						phase_q <= 1'b1;
						dir_q   <= '0;
						dist_q  <= 2'd1;
						state_q <= S_RD;
					end
				end
				S_PEND: begin
					if (lin_cnt_q != '0) begin
						meth_sel_q <= gshp_pkg::METH_PLANE;
						state_q    <= S_ABS;
					end else if (any_valid_q) begin
						scan_addr_q <= '0;
						scan_x_q    <= '0;
						scan_y_q    <= '0;
						found_q     <= 1'b0;
						state_q     <= S_SCAN;
					end else begin
						est_q   <= last_q;
						cnt_q   <= '0;
						meth_q  <= gshp_pkg::METH_LAST;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_ABS: begin
					neg_q     <= div_src[AC-1];
					dq_q      <= alu_s;
					div_cnt_q <= (meth_sel_q == gshp_pkg::METH_QUAD) ? quad_cnt_q : lin_cnt_q;
					rem_q     <= '0;
					bit_q     <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					// restoring divide of the magnitude, one quotient bit a cycle
					if (!alu_s[AC-1]) begin
						rem_q <= alu_s[CW-1:0];
						dq_q  <= {dq_q[AC-2:0], 1'b1};
					end else begin
						rem_q <= trial_in[CW-1:0];
						dq_q  <= {dq_q[AC-2:0], 1'b0};
					end
					bit_q <= bit_q + 1'b1;
					if (bit_q == LAST_BIT) begin
						state_q <= S_SIGN;
					end
				end
				S_SIGN: begin
					est_q   <= sat_v[HW-1:0];
					cnt_q   <= div_cnt_q;
					meth_q  <= meth_sel_q;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (scan_y_q == LAST_Y) begin
						scan_y_q <= '0;
						scan_x_q <= scan_x_q + 1'b1;
					end else begin
						scan_y_q <= scan_y_q + 1'b1;
					end
					if (scan_addr_q == LAST_CELL) begin
						drain_q <= 1'b0;
						state_q <= S_DRAIN;
					end else begin
						scan_addr_q <= scan_addr_q + 1'b1;
					end
				end
				S_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= S_NOUT;
					end
				end
				S_NOUT: begin
					if (found_q) begin
						est_q  <= near_h_q;
						cnt_q  <= CW'(1);
						meth_q <= gshp_pkg::METH_NEAR;
					end else begin
						est_q  <= last_q;
						cnt_q  <= '0;
						meth_q <= gshp_pkg::METH_LAST;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/gshp_checker.sv @@
// port-level checker for the height predictor, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gshp_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 func,
	input logic                                 done,
	input logic signed [gshp_pkg::HEIGHT_W-1:0] height_estimate,
	input logic [gshp_pkg::COUNT_W-1:0]         estimate_count,
	input logic [gshp_pkg::METH_W-1:0]          method_used
);

	logic acc_store, acc_guess, store_out, fixed_meth, near_meth, store_zero;

	assign acc_store  = start && !busy && (func == gshp_pkg::FUNC_STORE);
	assign acc_guess  = start && !busy && (func == gshp_pkg::FUNC_GUESS);
	assign store_out  = done && (method_used == gshp_pkg::METH_STORE);
	assign near_meth  = (method_used == gshp_pkg::METH_NEAR);
	assign fixed_meth = near_meth || (method_used == gshp_pkg::METH_LAST);
	assign store_zero = (height_estimate == 32'sd0) && (estimate_count == 4'd0);

	// a result only follows an accepted store or a cycle of work
	`ASSERT_IMP(a_done_src, clk, arst_n, done, $past(busy) || $past(start && !busy))
	`ASSERT_IMP(a_store_zero, clk, arst_n, store_out, store_zero)
	`ASSERT_IMP(a_count_meth, clk, arst_n, done && fixed_meth, estimate_count == {3'd0, near_meth})
	`ASSERT_NXT(a_store_done, clk, arst_n, acc_store, store_out)
	`ASSERT_NXT(a_guess_busy, clk, arst_n, acc_guess, busy)

endmodule

bind grid_surface_height_predictor gshp_checker u_gshp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.func            (func),
	.done            (done),
	.height_estimate (height_estimate),
	.estimate_count  (estimate_count),
	.method_used     (method_used)
);

@@ test/tb_grid_surface_height_predictor.sv @@
// self-checking testbench of the grid surface height predictor
`timescale 1ns / 1ps

module tb_grid_surface_height_predictor;

	localparam int COLS = 64;
	localparam int ROWS = 64;

	typedef struct {
		logic signed [gshp_pkg::HEIGHT_W-1:0] est;
		logic [gshp_pkg::COUNT_W-1:0]         cnt;
		logic [gshp_pkg::METH_W-1:0]          meth;
	} height_result_t;

	// kind: 0 guess, 1 store, 2 register write
	typedef struct {
		int  kind;
		int  col;
		int  row;
		int  hgt;
		bit  fixed;
		int  e_est;
		int  e_cnt;
		logic [gshp_pkg::METH_W-1:0] e_meth;
	} dir_row_t;

	localparam int KIND_GUESS = 0;
	localparam int KIND_STORE = 1;
	localparam int KIND_CFG   = 2;
	localparam int HMAX = 32'sh7fffffff;
	localparam int HMIN = 32'sh80000000;

	logic clk, arst_n, start, busy, func, done, initial_height_we;
	logic [gshp_pkg::INDEX_W-1:0] column_index, row_index;
	logic signed [gshp_pkg::HEIGHT_W-1:0] measured_height, height_estimate, initial_height;
	logic [gshp_pkg::COUNT_W-1:0] estimate_count;
	logic [gshp_pkg::METH_W-1:0] method_used;

	grid_surface_height_predictor DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.column_index(column_index), .row_index(row_index),
		.measured_height(measured_height), .done(done),
		.height_estimate(height_estimate), .estimate_count(estimate_count),
		.method_used(method_used), .initial_height_we(initial_height_we),
		.initial_height(initial_height)
	);

	// own copy of the block state
	logic signed [gshp_pkg::HEIGHT_W-1:0] surface[COLS*ROWS];
	bit                                   surface_ok[COLS*ROWS];
	logic signed [gshp_pkg::HEIGHT_W-1:0] last_height;
	int                                   stored_cells;

	height_result_t pending_heights[$];
	int errors;
	int idle_pct;
	int method_seen[6];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#500ms;
		$display("TB_ERROR");
		$finish;
	end

	function automatic bit fetch_cell(int c, int r, output longint z);
		z = 0;
		if (c < 0 || r < 0 || c >= COLS || r >= ROWS) return 0;
		if (!surface_ok[c*ROWS + r]) return 0;
		z = surface[c*ROWS + r];
		return 1;
	endfunction

	function automatic height_result_t predict_guess(int c, int r);
		height_result_t res;
		longint sum, a, b, d, q, best, d2;
		int n, k, dc, dr, x, y;
		sum = 0;
		n = 0;
		res.est = 0;
		res.meth = gshp_pkg::METH_LAST;
		for (k = 0; k < 8; k++) begin
			dc = gshp_pkg::dir_col(k[2:0]);
			dr = gshp_pkg::dir_row(k[2:0]);
			if (fetch_cell(c+dc, r+dr, a) && fetch_cell(c+2*dc, r+2*dr, b) &&
					fetch_cell(c+3*dc, r+3*dr, d)) begin
				sum += 3*a - 3*b + d;
				n++;
			end
		end
		if (n != 0) res.meth = gshp_pkg::METH_QUAD;
		else begin
			for (k = 0; k < 8; k++) begin
				dc = gshp_pkg::dir_col(k[2:0]);
				dr = gshp_pkg::dir_row(k[2:0]);
				if (fetch_cell(c+dc, r+dr, a) && fetch_cell(c+2*dc, r+2*dr, b)) begin
					sum += 2*a - b;
					n++;
				end
			end
			if (n != 0) res.meth = gshp_pkg::METH_LIN;
		end
		if (n == 0) begin
			for (k = 0; k < 4; k++) begin
				dc = gshp_pkg::quad_col(k[1:0]);
				dr = gshp_pkg::quad_row(k[1:0]);
				if (fetch_cell(c+dc, r+dr, a) && fetch_cell(c, r+dr, b) &&
						fetch_cell(c+dc, r, d)) begin
					sum += d + b - a;
					n++;
				end
			end
			if (n != 0) res.meth = gshp_pkg::METH_PLANE;
		end
		if (n != 0) begin
			q = sum / n;
			if (q > longint'(HMAX)) q = HMAX;
			if (q < longint'(HMIN)) q = HMIN;
			res.est = q[31:0];
		end else if (stored_cells != 0) begin
			// nearest by squared distance, first hit wins ties
			best = -1;
			for (x = 0; x < COLS; x++)
				for (y = 0; y < ROWS; y++)
					if (surface_ok[x*ROWS + y]) begin
						d2 = (x-c)*(x-c) + (y-r)*(y-r);
						if (best < 0 || d2 < best) begin
							best = d2;
							res.est = surface[x*ROWS + y];
						end
					end
			n = 1;
			res.meth = gshp_pkg::METH_NEAR;
		end else begin
			res.est = last_height;
		end
		res.cnt = n[gshp_pkg::COUNT_W-1:0];
		return res;
	endfunction

	task automatic send_item(bit f, int c, int r, int h, bit fixed, height_result_t fx);
		height_result_t res;
		func <= f;
		column_index <= c[gshp_pkg::INDEX_W-1:0];
		row_index <= r[gshp_pkg::INDEX_W-1:0];
		measured_height <= h;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (f == gshp_pkg::FUNC_STORE) begin
			res.est = 0;
			res.cnt = 0;
			res.meth = gshp_pkg::METH_STORE;
			if (!surface_ok[c*ROWS + r]) stored_cells++;
			surface_ok[c*ROWS + r] = 1;
			surface[c*ROWS + r] = h;
			last_height = h;
		end else begin
			res = predict_guess(c, r);
		end
		method_seen[res.meth]++;
		if (fixed) res = fx;
		pending_heights = {pending_heights, res};
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic write_initial(int v);
		start <= 1'b0;
		@(posedge clk);
		while (pending_heights.size() != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
		initial_height_we <= 1'b1;
		initial_height <= v;
		@(posedge clk);
		initial_height_we <= 1'b0;
		last_height = v;
	endtask

	always @(posedge clk) begin
		height_result_t want;
		if (done) begin
			if (pending_heights.size() == 0) begin
				$error("result with nothing pending");
				errors++;
			end else begin
				want = pending_heights.pop_front();
				if (height_estimate !== want.est) begin
					$error("height_estimate exp %0d got %0d", want.est, height_estimate);
					errors++;
				end
				if (estimate_count !== want.cnt) begin
					$error("estimate_count exp %0d got %0d", want.cnt, estimate_count);
					errors++;
				end
				if (method_used !== want.meth) begin
					$error("method_used exp %0d got %0d", want.meth, method_used);
					errors++;
				end
			end
		end
	end

	dir_row_t dir_tab[] = '{
		'{KIND_CFG,   0,  0,  HMAX, 0, 0,    0, gshp_pkg::METH_LAST},
		'{KIND_GUESS, 0,  0,  0,    1, HMAX, 0, gshp_pkg::METH_LAST},
		'{KIND_CFG,   0,  0,  HMIN, 0, 0,    0, gshp_pkg::METH_LAST},
		'{KIND_GUESS, 63, 63, 5,    1, HMIN, 0, gshp_pkg::METH_LAST},
		'{KIND_STORE, 63, 63, HMAX, 1, 0,    0, gshp_pkg::METH_STORE},
		'{KIND_GUESS, 0,  0,  0,    1, HMAX, 1, gshp_pkg::METH_NEAR},
		'{KIND_STORE, 0,  1,  HMAX, 1, 0,    0, gshp_pkg::METH_STORE},
		'{KIND_STORE, 0,  2,  HMIN, 1, 0,    0, gshp_pkg::METH_STORE},
		'{KIND_STORE, 0,  3,  HMAX, 1, 0,    0, gshp_pkg::METH_STORE},
		'{KIND_GUESS, 0,  0,  0,    1, HMAX, 1, gshp_pkg::METH_QUAD},
		'{KIND_GUESS, 0,  4,  0,    0, 0,    0, gshp_pkg::METH_LAST},
		'{KIND_GUESS, 0,  5,  0,    0, 0,    0, gshp_pkg::METH_LAST},
		'{KIND_STORE, 1,  0,  HMIN, 1, 0,    0, gshp_pkg::METH_STORE},
		'{KIND_STORE, 1,  1,  -7,   1, 0,    0, gshp_pkg::METH_STORE},
		'{KIND_GUESS, 1,  2,  0,    0, 0,    0, gshp_pkg::METH_LAST},
		'{KIND_GUESS, 2,  2,  0,    0, 0,    0, gshp_pkg::METH_LAST},
		'{KIND_STORE, 63, 0,  0,    1, 0,    0, gshp_pkg::METH_STORE},
		'{KIND_STORE, 62, 0,  123,  1, 0,    0, gshp_pkg::METH_STORE},
		'{KIND_GUESS, 62, 1,  0,    0, 0,    0, gshp_pkg::METH_LAST},
		'{KIND_STORE, 0,  1,  1,    1, 0,    0, gshp_pkg::METH_STORE},
		'{KIND_GUESS, 0,  0,  0,    0, 0,    0, gshp_pkg::METH_LAST},
		'{KIND_GUESS, 32, 31, 0,    0, 0,    0, gshp_pkg::METH_LAST},
		'{KIND_CFG,   0,  0,  0,    0, 0,    0, gshp_pkg::METH_LAST}
	};

	function automatic int random_height();
		case ($urandom_range(9))
			0: return HMAX;
			1: return HMIN;
			2, 3, 4: return $urandom;
			default: return int'($urandom_range(2**21)) - 2**20;
		endcase
	endfunction

	initial begin
		height_result_t fx;
		int i, p, wc, wr, c, r, sel;
		errors = 0;
		idle_pct = 19;
		stored_cells = 0;
		last_height = 0;
		for (i = 0; i < COLS*ROWS; i++) surface_ok[i] = 0;
		arst_n = 1'b0;
		start = 1'b0;
		func = gshp_pkg::FUNC_GUESS;
		column_index = '0;
		row_index = '0;
		measured_height = '0;
		initial_height_we = 1'b0;
		initial_height = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// clearing pass after reset
		while (busy) @(posedge clk);

		foreach (dir_tab[j]) begin
			if (dir_tab[j].kind == KIND_CFG) write_initial(dir_tab[j].hgt);
			else begin
				fx.est = dir_tab[j].e_est;
				fx.cnt = dir_tab[j].e_cnt[gshp_pkg::COUNT_W-1:0];
				fx.meth = dir_tab[j].e_meth;
				send_item(dir_tab[j].kind == KIND_STORE, dir_tab[j].col, dir_tab[j].row,
					dir_tab[j].hgt, dir_tab[j].fixed, fx);
			end
		end

		for (p = 0; p < 6; p++) begin
			idle_pct = (p < 2) ? 19 : (p < 4) ? 79 : 0;
			write_initial($urandom);
			for (i = 0; i < 215; i++) begin
				// a new 8x8 patch now and then, hit by stores and guesses inside it, a few anywhere on the grid
				if (i % 72 == 0) begin
					wc = $urandom_range(56);
					wr = $urandom_range(56);
				end
				c = wc + $urandom_range(7);
				r = wr + $urandom_range(7);
				sel = $urandom_range(99);
				if (sel <= 44) begin
					send_item(gshp_pkg::FUNC_STORE, c, r, random_height(), 0, fx);
				end else if (sel <= 94) begin
					send_item(gshp_pkg::FUNC_GUESS, c, r, random_height(), 0, fx);
				end else if (sel <= 97) begin
					send_item(gshp_pkg::FUNC_STORE, $urandom_range(63), $urandom_range(63),
						random_height(), 0, fx);
				end else begin
					send_item(gshp_pkg::FUNC_GUESS, $urandom_range(63), $urandom_range(63),
						random_height(), 0, fx);
				end
			end
		end

		start <= 1'b0;
		while (pending_heights.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("stores %0d, guesses: last %0d quad %0d lin %0d plane %0d nearest %0d",
			method_seen[gshp_pkg::METH_STORE], method_seen[gshp_pkg::METH_LAST],
			method_seen[gshp_pkg::METH_QUAD], method_seen[gshp_pkg::METH_LIN],
			method_seen[gshp_pkg::METH_PLANE], method_seen[gshp_pkg::METH_NEAR]);
		$display("initial height written at both extremes and six random values");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/gshp_pkg.sv
sv/gshp_ram.sv
sv/gshp_alu.sv
sv/grid_surface_height_predictor.sv
sv/gshp_checker.sv
test/tb_grid_surface_height_predictor.sv
